// ===== rtl/cascaded_stereo_slew_limiter_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the cascaded stereo slew limiter
// Shared concurrent check forms, clocked on the rising edge, reset disabled.
// ---------------------------------------------------------------------------
`ifndef CASCADED_STEREO_SLEW_LIMITER_DEFINES_SVH
`define CASCADED_STEREO_SLEW_LIMITER_DEFINES_SVH

// condition holds at every edge outside reset
`define CSL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("csl check failed: invariant");

// consequent holds in the same cycle as the antecedent
`define CSL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csl check failed: implication");

// consequent holds in the cycle after the antecedent
`define CSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csl check failed: next-cycle implication");

`endif

// ===== rtl/csl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csl_pkg
// Widths, constants and shared types of the cascaded stereo slew limiter.
// ---------------------------------------------------------------------------
package csl_pkg;

   localparam int STAGE_COUNT = 10;
   localparam int SAMPLE_BITS = 24;
   localparam int LIMIT_BITS  = 25;

   // golden ratio, unsigned with 32 fraction bits
   localparam int PHI_BITS = 33;
   localparam logic [PHI_BITS-1:0] PHI_Q32 = 33'd6949403065;

   // limit times golden ratio, and the half LSB added before dropping 32 bits
   localparam int PROD_BITS = LIMIT_BITS + PHI_BITS;
   localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(64'd2147483648);

   localparam logic [LIMIT_BITS-1:0] LIMIT_MAX  = {LIMIT_BITS{1'b1}};
   localparam logic [LIMIT_BITS-1:0] BASE_RESET = LIMIT_BITS'(8388608);

   localparam int STAGE_IDX_BITS = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

   // two samples packed, padded to whole bytes
   localparam int DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

   // working width of the step compare: holds a sample difference and a limit
   localparam int WIDE_BITS = (SAMPLE_BITS + 2 > LIMIT_BITS + 1) ?
                              SAMPLE_BITS + 2 : LIMIT_BITS + 1;

   typedef logic signed [SAMPLE_BITS-1:0]     sample_type;
   typedef logic [LIMIT_BITS-1:0]             limit_type;
   typedef limit_type [STAGE_COUNT-1:0]       limit_array_type;

   typedef struct packed {
      logic [STAGE_COUNT-1:0] load;
   } csl_flow_type;

endpackage

// ===== rtl/csl_limit_seq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csl_limit_seq
// Holds the per-stage step limits. After reset or a register write it walks
// from the last stage back to the first, one golden-ratio multiply a cycle.
// ---------------------------------------------------------------------------
`include "cascaded_stereo_slew_limiter_defines.svh"

module csl_limit_seq
   import csl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_BITS-1:0] csr_data,
   output logic                  busy,
   output limit_array_type       limits
);

   limit_array_type           limits_ff;
   limit_type                 work_ff;
   logic [STAGE_IDX_BITS-1:0] idx_ff;
   logic                      busy_ff;

   logic [PROD_BITS-1:0]          prod;
   logic [PROD_BITS-1:0]          rounded;
   logic [PROD_BITS-33:0]         quot;
   limit_type                     next_limit;

   always_comb begin
      prod       = PROD_BITS'(work_ff) * PROD_BITS'(PHI_Q32);
      rounded    = prod + ROUND_HALF;
      quot       = rounded[PROD_BITS-1:32];
      next_limit = (quot > (PROD_BITS-32)'(LIMIT_MAX)) ? LIMIT_MAX : quot[LIMIT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff[STAGE_COUNT-1] <= BASE_RESET;
         work_ff                  <= BASE_RESET;
         idx_ff                   <= STAGE_IDX_BITS'(STAGE_COUNT - 1);
         busy_ff                  <= (STAGE_COUNT > 1);
      end else if (csr_valid && csr_ready) begin
         limits_ff[STAGE_COUNT-1] <= csr_data;
         work_ff                  <= csr_data;
         idx_ff                   <= STAGE_IDX_BITS'(STAGE_COUNT - 1);
         busy_ff                  <= (STAGE_COUNT > 1);
      end else if (busy_ff) begin
         // step toward the first stage
         limits_ff[idx_ff - 1'b1] <= next_limit;
         work_ff                  <= next_limit;
         idx_ff                   <= idx_ff - 1'b1;
         if (idx_ff == STAGE_IDX_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign csr_ready = !busy_ff;
   assign busy      = busy_ff;
   assign limits    = limits_ff;

   `CSL_ASSERT_NEXT(a_write_starts_walk, clock, reset, csr_valid && csr_ready,
                    busy_ff || (STAGE_COUNT == 1))
   `CSL_ASSERT_NEXT(a_walk_ends, clock, reset, busy_ff && (idx_ff == STAGE_IDX_BITS'(1)),
                    !busy_ff)
   `CSL_ASSERT_ALWAYS(a_idle_index_home, clock, reset, busy_ff || (idx_ff == '0))

endmodule

// ===== rtl/csl_flow.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csl_flow
// Valid and ready chain of the stage pipeline, shared by both lanes, and the
// frame end marker that travels beside the samples.
// ---------------------------------------------------------------------------
module csl_flow
   import csl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         busy,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tlast,
   output csl_flow_type flow
);

   logic [STAGE_COUNT-1:0] valid_ff;
   logic [STAGE_COUNT-1:0] valid_in;
   logic [STAGE_COUNT-1:0] end_ff;
   logic [STAGE_COUNT-1:0] rdy;
   logic [STAGE_COUNT-1:0] load;

   always_comb begin
      rdy[STAGE_COUNT-1] = !valid_ff[STAGE_COUNT-1] || rsp_tready;
      for (int k = STAGE_COUNT - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      load[0] = req_tvalid && rdy[0] && !busy;
      for (int k = 1; k < STAGE_COUNT; k++) begin
         load[k] = valid_ff[k-1] && rdy[k];
      end
      // a valid stage that is ready hands its frame on
      valid_in = load | (valid_ff & ~rdy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         end_ff[0] <= req_tlast;
      end
      for (int k = 1; k < STAGE_COUNT; k++) begin
         if (load[k]) begin
            end_ff[k] <= end_ff[k-1];
         end
      end
   end

   assign req_tready = rdy[0] && !busy;
   assign rsp_tvalid = valid_ff[STAGE_COUNT-1];
   assign rsp_tlast  = end_ff[STAGE_COUNT-1];
   assign flow.load  = load;

endmodule

// ===== rtl/csl_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csl_lane
// One channel: a chain of slew stages. Each stage register is both the
// pipeline register and that stage's previous output.
// ---------------------------------------------------------------------------
module csl_lane
   import csl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  csl_flow_type    flow,
   input  limit_array_type limits,
   input  sample_type      sample_in,
   output sample_type      sample_out
);

   sample_type stage_ff [STAGE_COUNT];
   sample_type stage_in [STAGE_COUNT];
   sample_type stage_x  [STAGE_COUNT];

   function automatic sample_type slew(sample_type x, sample_type p, limit_type lim);
      logic signed [WIDE_BITS-1:0] xw;
      logic signed [WIDE_BITS-1:0] pw;
      logic signed [WIDE_BITS-1:0] lw;
      logic signed [WIDE_BITS-1:0] d;
      logic signed [WIDE_BITS-1:0] y;
      xw = WIDE_BITS'(x);
      pw = WIDE_BITS'(p);
      lw = $signed(WIDE_BITS'(lim));
      d  = xw - pw;
      if (d > lw) begin
         y = pw + lw;
      end else if (-d > lw) begin
         y = pw - lw;
      end else begin
         y = xw;
      end
      return y[SAMPLE_BITS-1:0];
   endfunction

   assign stage_x[0] = sample_in;
   for (genvar k = 1; k < STAGE_COUNT; k++) begin : g_link
      assign stage_x[k] = stage_ff[k-1];
   end

   always_comb begin
      for (int k = 0; k < STAGE_COUNT; k++) begin
         stage_in[k] = slew(stage_x[k], stage_ff[k], limits[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGE_COUNT; k++) begin
            stage_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < STAGE_COUNT; k++) begin
            if (flow.load[k]) begin
               stage_ff[k] <= stage_in[k];
            end
         end
      end
   end

   assign sample_out = stage_ff[STAGE_COUNT-1];

endmodule

// ===== rtl/cascaded_stereo_slew_limiter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cascaded_stereo_slew_limiter
// Stereo slew limiter: ten limiter stages in series per channel.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : input frames. req_tdata = {right, left}, req_tlast = buffer end.
//   rsp_*  : limited frames in the same packing, rsp_tlast copies req_tlast.
//   csr_*  : write of the base step limit (25 bits, unsigned Q2.23).
// Pipeline: a frame passes one register per stage on its way to rsp_tvalid.
// Throughput: each stage register holds its own state, so the chain takes
//   one frame per cycle while rsp_tready is high and no derivation runs.
// Reset: stage outputs clear to zero, the base limit returns to 1.0, and the
//   earlier limits are derived by one multiply per cycle while req_tready and
//   csr_ready are low. A register write starts the same derivation.
// Stall: when rsp_tready is low the last stage holds; bubbles upstream still
//   fill, and req_tready drops once every stage is occupied.
// ---------------------------------------------------------------------------
`include "cascaded_stereo_slew_limiter_defines.svh"

module cascaded_stereo_slew_limiter
   import csl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata, low bit up: sample_left, sample_right, zero pad
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_BITS-1:0]  req_tdata,
   input  logic                  req_tlast,
   // rsp_tdata, low bit up: limited_left, limited_right, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_BITS-1:0]  rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_BITS-1:0] csr_data
);

   logic            busy;
   limit_array_type limits;
   csl_flow_type    flow;
   sample_type      left_out;
   sample_type      right_out;

   csl_limit_seq u_limit_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .busy      (busy),
      .limits    (limits)
   );

   csl_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .busy       (busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .flow       (flow)
   );

   csl_lane u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .flow       (flow),
      .limits     (limits),
      .sample_in  (req_tdata[SAMPLE_BITS-1:0]),
      .sample_out (left_out)
   );

   csl_lane u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .flow       (flow),
      .limits     (limits),
      .sample_in  (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .sample_out (right_out)
   );

   // merge both lanes into one result word
   assign rsp_tdata = DATA_BITS'({right_out, left_out});

   `CSL_ASSERT_IMPL(a_no_transfer_while_deriving, clock, reset,
                    req_tvalid && req_tready, !busy)

endmodule

// ===== tb/cascaded_stereo_slew_limiter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cascaded_stereo_slew_limiter_tb
// Drives stereo frames through the slew limiter under several base limits and
// idle patterns. A behavioral copy of the stage chain predicts every output
// frame, and each result transfer is checked field by field in order.
// ---------------------------------------------------------------------------
module cascaded_stereo_slew_limiter_tb;
   import csl_pkg::*;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam int RANDOM_FRAMES = 1600;
   localparam int LIMIT_SETS    = 4;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       last;
   } limited_frame_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [LIMIT_BITS-1:0] csr_data = '0;

   // predictor state
   limit_type         stage_limit [STAGE_COUNT];
   longint            held_left   [STAGE_COUNT];
   longint            held_right  [STAGE_COUNT];
   limited_frame_type pending_frames [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int frames_sent      = 0;
   int frames_checked   = 0;
   int threshold_writes = 0;
   int mismatch_count   = 0;

   cascaded_stereo_slew_limiter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Each earlier stage gets the golden ratio times the next stage's limit.
   function automatic void derive_stage_limits(input limit_type base);
      logic [63:0] lim;
      int k;
      lim = 64'(base);
      for (k = STAGE_COUNT - 1; k >= 0; k--) begin
         stage_limit[k] = limit_type'(lim);
         lim = (lim * 64'(PHI_Q32) + 64'h8000_0000) >> 32;
         if (lim > 64'(LIMIT_MAX))
            lim = 64'(LIMIT_MAX);
      end
   endfunction

   function automatic longint clamp_step(input longint x, input longint prev,
                                         input longint lim);
      longint step;
      step = x - prev;
      if (step > lim)
         return prev + lim;
      if (-step > lim)
         return prev - lim;
      return x;
   endfunction

   function automatic limited_frame_type limit_frame(input sample_type l,
                                                     input sample_type r,
                                                     input logic last);
      longint chan_l, chan_r, lim;
      limited_frame_type f;
      int k;
      chan_l = l;
      chan_r = r;
      for (k = 0; k < STAGE_COUNT; k++) begin
         lim = longint'(stage_limit[k]);
         chan_l = clamp_step(chan_l, held_left[k], lim);
         chan_r = clamp_step(chan_r, held_right[k], lim);
         held_left[k]  = chan_l;
         held_right[k] = chan_r;
      end
      f.left  = sample_type'(chan_l);
      f.right = sample_type'(chan_r);
      f.last  = last;
      return f;
   endfunction

   // Mix of full-scale noise, small steps, rail values and repeats.
   function automatic sample_type next_sample(input sample_type prev);
      int roll;
      longint v;
      roll = $urandom_range(99);
      if (roll < 40)
         return sample_type'($urandom);
      if (roll < 70) begin
         v = longint'(prev) + longint'($urandom_range(0, 1 << $urandom_range(0, 20)))
             * (($urandom_range(1) != 0) ? 1 : -1);
         if (v > longint'(SAMPLE_MAX))
            v = SAMPLE_MAX;
         if (v < longint'(SAMPLE_MIN))
            v = SAMPLE_MIN;
         return sample_type'(v);
      end
      if (roll < 85) begin
         case ($urandom_range(2))
            0: begin
               return SAMPLE_MAX;
            end
            1: begin
               return SAMPLE_MIN;
            end
            default: begin
               return '0;
            end
         endcase
      end
      return prev;
   endfunction

   function automatic limit_type pick_threshold();
      case ($urandom_range(3))
         0: begin
            return limit_type'($urandom_range(0, 65535));
         end
         1: begin
            return limit_type'($urandom);
         end
         2: begin
            return limit_type'($urandom_range(262144, 4194304));
         end
         default: begin
            return ($urandom_range(1) != 0) ? LIMIT_MAX : limit_type'($urandom_range(0, 7));
         end
      endcase
   endfunction

   task automatic send_frame(input sample_type l, input sample_type r, input logic last);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_BITS'({r, l});
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pending_frames.push_back(limit_frame(l, r, last));
      frames_sent++;
   endtask

   // Hold the sender off until every outstanding frame has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_threshold(input limit_type value);
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      derive_stage_limits(value);
      threshold_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      limited_frame_type want;
      sample_type got_left, got_right;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_left  = rsp_tdata[SAMPLE_BITS-1:0];
         got_right = rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         if (pending_frames.size() == 0) begin
            $error("result transfer with no frame outstanding");
            mismatch_count++;
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            if (got_left !== want.left) begin
               $error("limited_left: expected %0d, got %0d", want.left, got_left);
               mismatch_count++;
            end
            if (got_right !== want.right) begin
               $error("limited_right: expected %0d, got %0d", want.right, got_right);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("block_end_out: expected %0b, got %0b", want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // Reset limit: zero stays zero, rail-to-rail jumps get clamped.
   task automatic test_reset_limit();
      send_frame('0, '0, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
      send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
      send_frame(-24'sd1, 24'sd1, 1'b1);
   endtask

   // Zero limit: every stage holds its output.
   task automatic test_zero_limit();
      write_threshold('0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_frame(24'sd1, -24'sd1, 1'b1);
      send_frame('0, '0, 1'b0);
   endtask

   // Largest base limit: all stage limits saturate and frames pass through.
   task automatic test_saturated_limit();
      write_threshold(LIMIT_MAX);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_frame('0, '0, 1'b1);
   endtask

   task automatic test_unit_limit();
      write_threshold(limit_type'(1));
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
      send_frame('0, '0, 1'b0);
      send_frame(24'sd1, -24'sd1, 1'b0);
   endtask

   task automatic test_half_scale_limit();
      write_threshold(limit_type'(24'h7f_ffff));
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int frame_total);
      sample_type l, r;
      int s;
      l = '0;
      r = '0;
      send_idle_pct = sender_idle;
      stall_pct     = receiver_stall;
      for (s = 0; s < LIMIT_SETS; s++) begin
         write_threshold(pick_threshold());
         repeat (frame_total / LIMIT_SETS) begin
            l = next_sample(l);
            r = next_sample(r);
            send_frame(l, r, $urandom_range(15) == 0);
         end
      end
   endtask

   initial begin
      int k;
      for (k = 0; k < STAGE_COUNT; k++) begin
         held_left[k]  = 0;
         held_right[k] = 0;
      end
      derive_stage_limits(BASE_RESET);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_limit();
      test_zero_limit();
      test_saturated_limit();
      test_unit_limit();
      test_half_scale_limit();
      test_random_traffic(13, 84, RANDOM_FRAMES / 3);
      test_random_traffic(84, 13, RANDOM_FRAMES / 3);
      test_random_traffic(0, 0, RANDOM_FRAMES / 3);

      wait_for_results();
      repeat (4 * STAGE_COUNT) @(posedge clock);
      $display("Covered %0d frames and %0d checked results over %0d base limit writes,",
               frames_sent, frames_checked, threshold_writes);
      $display("including zero, unit and saturated limits under three idle patterns.");
      if (mismatch_count == 0 && pending_frames.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
